// File: design/erc_pkg.sv
// shared types, symbol codes and crc helper for the escaped frame receiver
// no dependencies; imported by all modules of the block, not by the interfaces
package erc_pkg;

    localparam logic [7:0]  SYM_SOH  = 8'h01;
    localparam logic [7:0]  SYM_EOT  = 8'h04;
    localparam logic [7:0]  SYM_DLE  = 8'h10;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic CMD_BYTE    = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    typedef struct packed {
        logic       command;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic       data_valid;
        logic [7:0] data_byte;
        logic [7:0] data_index;
        logic       frame_good;
        logic [7:0] payload_length;
        logic       frame_pending;
        logic       dropped;
    } result_t;

    // crc-16 xmodem, one byte msb first
    function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// File: design/erc_in_if.sv
// input channel of the escaped frame receiver: command and raw link byte
// depends on nothing but the valid/ready handshake
interface erc_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] rx_byte;

    modport source (output valid, output command, output rx_byte, input ready);
    modport sink   (input valid, input command, input rx_byte, output ready);
endinterface

// File: design/erc_out_if.sv
// result channel of the escaped frame receiver: one result per input transfer
// depends on nothing but the valid/ready handshake
interface erc_out_if;
    logic       valid;
    logic       ready;
    logic       data_valid;
    logic [7:0] data_byte;
    logic [7:0] data_index;
    logic       frame_good;
    logic [7:0] payload_length;
    logic       frame_pending;
    logic       dropped;

    modport source (output valid, output data_valid, output data_byte, output data_index,
                    output frame_good, output payload_length, output frame_pending,
                    output dropped, input ready);
    modport sink   (input valid, input data_valid, input data_byte, input data_index,
                    input frame_good, input payload_length, input frame_pending,
                    input dropped, output ready);
endinterface

// File: design/erc_core.sv
// deframing state and per-byte decode: escape flag, store length, running crc
// depends on erc_pkg; advances its state once for every item it is told to take
module erc_core
    import erc_pkg::*;
#(
    parameter int BUFFER_BYTES = 256
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    fire,
    input  item_t   item,
    output result_t res
);

    localparam int LEN_W = $clog2(BUFFER_BYTES + 1);
    localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(BUFFER_BYTES);

    logic             escape_reg,  escape_next;
    logic [LEN_W-1:0] len_reg,     len_next;
    logic [15:0]      crc_reg,     crc_next;
    logic [7:0]       older_reg,   older_next;
    logic [7:0]       newer_reg,   newer_next;
    logic             good_reg,    good_next;

    logic [LEN_W-1:0] len_eff;
    logic [15:0]      crc_eff;
    logic [LEN_W-1:0] len_minus2;
    logic [LEN_W+7:0] len_ext;
    logic [LEN_W+7:0] pl_ext;
    logic             store;

    always_comb
    begin
        escape_next = escape_reg;
        len_next    = len_reg;
        crc_next    = crc_reg;
        older_next  = older_reg;
        newer_next  = newer_reg;
        good_next   = good_reg;
        res         = '0;
        store       = 1'b0;

        // buffer full wraps the store back to the start
        len_eff    = (len_reg >= LEN_FULL) ? '0 : len_reg;
        crc_eff    = (len_reg >= LEN_FULL) ? 16'h0000 : crc_reg;
        len_minus2 = len_eff - LEN_W'(2);
        len_ext    = {8'h00, len_eff};
        pl_ext     = {8'h00, len_minus2};

        if (item.command == CMD_RELEASE)
        begin
            good_next = 1'b0;
        end
        else if (good_reg)
        begin
            res.dropped = 1'b1;
        end
        else
        begin
            len_next = len_eff;
            crc_next = crc_eff;
            if (escape_reg)
            begin
                store = 1'b1;
            end
            else
            begin
                case (item.rx_byte)
                    SYM_SOH:
                    begin
                        len_next = '0;
                        crc_next = 16'h0000;
                    end
                    SYM_EOT:
                    begin
                        if (len_eff > LEN_W'(2) && {newer_reg, older_reg} == crc_eff)
                        begin
                            good_next          = 1'b1;
                            res.frame_good     = 1'b1;
                            res.payload_length = pl_ext[7:0];
                        end
                    end
                    SYM_DLE:
                    begin
                        escape_next = 1'b1;
                    end
                    default:
                    begin
                        store = 1'b1;
                    end
                endcase
            end
            if (store)
            begin
                escape_next = 1'b0;
                // crc trails the store by the two held bytes
                if (len_eff >= LEN_W'(2))
                    crc_next = crc_feed(crc_eff, older_reg);
                older_next     = newer_reg;
                newer_next     = item.rx_byte;
                res.data_valid = 1'b1;
                res.data_byte  = item.rx_byte;
                res.data_index = len_ext[7:0];
                len_next       = len_eff + LEN_W'(1);
            end
        end
        res.frame_pending = good_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_reg <= 1'b0;
            len_reg    <= '0;
            crc_reg    <= 16'h0000;
            older_reg  <= 8'h00;
            newer_reg  <= 8'h00;
            good_reg   <= 1'b0;
        end
        else if (fire)
        begin
            escape_reg <= escape_next;
            len_reg    <= len_next;
            crc_reg    <= crc_next;
            older_reg  <= older_next;
            newer_reg  <= newer_next;
            good_reg   <= good_next;
        end
    end

    a_pending_drops: assert property (@(posedge clk) disable iff (!rst_n)
        fire && good_reg && item.command == CMD_BYTE |-> res.dropped && !res.data_valid)
        else $error("byte not dropped while a good frame is pending");

    a_good_sets_pending: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.frame_good |=> good_reg)
        else $error("good frame did not become pending");

    a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.command == CMD_RELEASE |=> !good_reg)
        else $error("release left a frame pending");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_FULL)
        else $error("store length beyond buffer size");

    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(crc_reg) && $stable(len_reg) && $stable(escape_reg))
        else $error("deframer state moved without a transfer");

endmodule

// File: design/escaped_frame_receiver_crc16.sv
// an item waits in the input register, its result in the result register until taken
// throughput: one item per cycle while results are taken; erc_core crc is combinational
// the input register refills in the same cycle that its item moves to the result register
// reset (rst_n, async, active low) clears the frame state, the crc and both channel
// valids; the block takes items in the first cycle after reset, no clearing pass
module escaped_frame_receiver_crc16
    import erc_pkg::*;
#(
    parameter int BUFFER_BYTES = 256
)
(
    input  logic              clk,
    input  logic              rst_n,
    erc_in_if.sink            link,
    erc_out_if.source         result
);

    logic    in_valid_reg,  in_valid_next;
    item_t   in_item_reg;
    logic    out_valid_reg, out_valid_next;
    result_t out_res_reg;
    result_t core_res;
    item_t   link_item;
    logic    move;
    logic    take;

    assign link_item.command = link.command;
    assign link_item.rx_byte = link.rx_byte;

    // item advances when the result register is empty or being emptied
    assign move      = in_valid_reg && (!out_valid_reg || result.ready);
    assign link.ready = !in_valid_reg || move;
    assign take      = link.valid && link.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
            in_valid_next = 1'b1;
        else if (move)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (move)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    erc_core #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (move),
        .item  (in_item_reg),
        .res   (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            in_item_reg <= link_item;
        if (move)
            out_res_reg <= core_res;
    end

    assign result.valid          = out_valid_reg;
    assign result.data_valid     = out_res_reg.data_valid;
    assign result.data_byte      = out_res_reg.data_byte;
    assign result.data_index     = out_res_reg.data_index;
    assign result.frame_good     = out_res_reg.frame_good;
    assign result.payload_length = out_res_reg.payload_length;
    assign result.frame_pending  = out_res_reg.frame_pending;
    assign result.dropped        = out_res_reg.dropped;

endmodule
